### sv/hssc_pkg.sv
// Shared types and constants for the hashed subtree size cache.
// Holds the queued job format, status and job codes, and the key mixing function.
// Depends on nothing.
`timescale 1ns / 1ps

package hssc_pkg;

  // Field widths of the item and of the stored slot.
  localparam int KEY_W    = 30;
  localparam int VAL_W    = 31;
  localparam int LIMIT_W  = 21;
  localparam int HASH_W   = 20;
  localparam int SLOT_W   = KEY_W + VAL_W;

  // Reset value of the fill limit register.
  localparam logic [LIMIT_W-1:0] FILL_LIMIT_RST = LIMIT_W'(131072);

  // Queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Operation codes on the input.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Mixing masks.
  localparam logic [31:0] MIX_M10 = 32'h0000_03ff;
  localparam logic [31:0] MIX_M15 = 32'h0000_7fff;
  localparam logic [31:0] MIX_M5  = 32'h0000_001f;
  localparam logic [31:0] MIX_MA  = 32'h0055_aa55;
  localparam logic [31:0] MIX_MB  = 32'h00aa_55aa;

  typedef enum logic [1:0] {
    JOB_LOOKUP,
    JOB_INSERT,
    JOB_REJECT
  } hssc_kind_t;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_MISS    = 2'd1,
    ST_DONE    = 2'd2,
    ST_REFUSED = 2'd3
  } hssc_status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PROBE
  } hssc_bk_state_t;

  // One classified item waiting for the probe engine.
  typedef struct packed {
    hssc_kind_t          kind;
    logic [KEY_W-1:0]    key;
    logic [VAL_W-1:0]    value;
    logic [HASH_W-1:0]   hash;
  } hssc_job_t;

  // Sum of the shift and mask terms of the hash, low HASH_W bits only.
  // The square of the key is added separately.
  function automatic logic [HASH_W-1:0] mix_side(input logic [KEY_W-1:0] key);
    logic [31:0] n;
    logic [31:0] inv;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [31:0] t4;
    logic [31:0] t5;
    logic [31:0] s;
    n   = {2'b00, key};
    inv = ~n;
    t1  = (n >> 10) ^ (inv & MIX_M10);
    t2  = ((n >> 5) ^ (inv & MIX_M15)) << 5;
    t3  = ((inv >> 15) ^ (n & MIX_M5)) << 5;
    t4  = (n >> 4) & MIX_MA;
    t5  = (inv >> 8) & MIX_MB;
    s   = t1 + t2 + t3 + t4 + t5;
    return s[HASH_W-1:0];
  endfunction

endpackage

### sv/hssc_front.sv
// Front end: accepts items, classifies them and computes the slot hash.
// Two register stages feed the job queue; depends on hssc_pkg.
`timescale 1ns / 1ps

module hssc_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic                                in_operation,
  input  logic [hssc_pkg::KEY_W-1:0]          in_key,
  input  logic [hssc_pkg::VAL_W-1:0]          in_size_value,
  input  logic                                clearing,
  input  logic [hssc_pkg::Q_CNT_W-1:0]        q_count,
  output logic                                q_push,
  output hssc_pkg::hssc_job_t                 q_wdata
);
  import hssc_pkg::*;

  logic                 v1_r;
  hssc_kind_t           kind1_r;
  logic [KEY_W-1:0]     key1_r;
  logic [VAL_W-1:0]     val1_r;
  logic [HASH_W-1:0]    sq_r;
  logic [HASH_W-1:0]    side_r;
  logic                 v2_r;
  hssc_job_t            job2_r;
  logic [2*HASH_W-1:0]  sq_full;
  logic [Q_CNT_W-1:0]   in_flight;
  logic                 accept;
  hssc_kind_t           kind_in;

  // Items in the stages hold a queue place, so the stages never stall.
  assign in_flight = q_count + Q_CNT_W'(v1_r) + Q_CNT_W'(v2_r);
  assign full      = clearing || (in_flight >= Q_CNT_W'(Q_DEPTH));
  assign accept    = push && !full;

  // Only the low hash bits of the square matter.
  assign sq_full = (2*HASH_W)'(in_key[HASH_W-1:0]) * (2*HASH_W)'(in_key[HASH_W-1:0]);

  // An insert with the empty-slot key can never be stored.
  always_comb begin
    if (in_operation == OP_LOOKUP) begin
      kind_in = JOB_LOOKUP;
    end else if (in_key == '0) begin
      kind_in = JOB_REJECT;
    end else begin
      kind_in = JOB_INSERT;
    end
  end

  // Stage one: square and side terms.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
    if (accept) begin
      kind1_r <= kind_in;
      key1_r  <= in_key;
      val1_r  <= in_size_value;
      sq_r    <= sq_full[HASH_W-1:0];
      side_r  <= mix_side(in_key);
    end
  end

  // Stage two: final hash, then into the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    if (v1_r) begin
      job2_r.kind  <= kind1_r;
      job2_r.key   <= key1_r;
      job2_r.value <= val1_r;
      job2_r.hash  <= sq_r + side_r;
    end
  end

  assign q_push  = v2_r;
  assign q_wdata = job2_r;

endmodule

### sv/hssc_queue.sv
// Short job queue between the front end and the probe engine.
// Depends on hssc_pkg for the job format and depth.
`timescale 1ns / 1ps

module hssc_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_push,
  input  hssc_pkg::hssc_job_t           q_wdata,
  input  logic                          q_pop,
  output hssc_pkg::hssc_job_t           q_rdata,
  output logic                          q_empty,
  output logic [hssc_pkg::Q_CNT_W-1:0]  q_count
);
  import hssc_pkg::*;

  hssc_job_t           slots_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_r;
  logic [Q_CNT_W-1:0]  count_r;
  logic [Q_CNT_W-1:0]  count_nxt;
  logic                do_pop;

  assign q_empty = (count_r == '0);
  assign q_count = count_r;
  assign q_rdata = slots_r[rd_ptr_r];
  assign do_pop  = q_pop && !q_empty;

  // Occupancy follows push and pop together.
  always_comb begin
    count_nxt = count_r;
    if (q_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!q_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (q_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
    if (q_push) begin
      slots_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

### sv/hssc_back.sv
// Probe engine: slot memory, clearing pass, linear probing and the result register.
// Takes jobs from hssc_queue; depends on hssc_pkg.
`timescale 1ns / 1ps

module hssc_back #(
  parameter int TABLE_ADDR_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hssc_pkg::hssc_job_t               q_rdata,
  input  logic                              q_empty,
  output logic                              q_pop,
  output logic                              clearing,
  input  logic                              cfg_wr_en,
  input  logic [hssc_pkg::LIMIT_W-1:0]      cfg_wr_data,
  output logic                              empty,
  input  logic                              pop,
  output logic [1:0]                        out_status,
  output logic [hssc_pkg::VAL_W-1:0]        out_found_value
);
  import hssc_pkg::*;

  localparam int AW = TABLE_ADDR_BITS;
  localparam int SLOT_COUNT = 1 << AW;
  localparam logic [AW-1:0] ADDR_ONE = AW'(1);

  logic [SLOT_W-1:0]   mem [SLOT_COUNT];
  logic [SLOT_W-1:0]   rd_data_r;

  hssc_bk_state_t      state_r;
  hssc_bk_state_t      state_nxt;
  logic [AW-1:0]       clr_addr_r;
  logic [AW-1:0]       addr_r;
  logic [AW-1:0]       addr_nxt;
  logic [AW-1:0]       cnt_r;
  logic [AW-1:0]       cnt_nxt;
  hssc_job_t           job_r;
  logic [LIMIT_W-1:0]  entry_count_r;
  logic [LIMIT_W-1:0]  fill_limit_r;
  logic                out_valid_r;
  hssc_status_t        out_status_r;
  logic [VAL_W-1:0]    out_value_r;

  logic                out_free;
  logic                start;
  logic                finish;
  logic                count_inc;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [SLOT_W-1:0]   mem_wdata;
  logic [AW-1:0]       rd_addr;
  logic                res_load;
  hssc_status_t        res_status;
  logic [VAL_W-1:0]    res_value;
  logic [KEY_W-1:0]    slot_key;
  logic                slot_empty;
  logic                last_probe;

  assign clearing        = (state_r == BK_CLEAR);
  assign empty           = !out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_value_r;
  assign out_free        = !out_valid_r || pop;
  assign slot_key        = rd_data_r[SLOT_W-1:VAL_W];
  assign slot_empty      = (slot_key == '0);
  assign last_probe      = &cnt_r;

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (&clr_addr_r) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (start) begin
          state_nxt = BK_PROBE;
        end
      end
      BK_PROBE: begin
        if (finish) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_CLEAR;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    q_pop      = 1'b0;
    start      = 1'b0;
    finish     = 1'b0;
    count_inc  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = addr_r;
    mem_wdata  = '0;
    rd_addr    = addr_r;
    addr_nxt   = addr_r;
    cnt_nxt    = cnt_r;
    res_load   = 1'b0;
    res_status = ST_MISS;
    res_value  = '0;
    case (state_r)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
      end
      BK_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (q_rdata.kind == JOB_REJECT ||
              (q_rdata.kind == JOB_INSERT && entry_count_r > fill_limit_r)) begin
            // Refused without touching the table.
            res_load   = 1'b1;
            res_status = ST_REFUSED;
          end else begin
            start    = 1'b1;
            rd_addr  = q_rdata.hash[AW-1:0];
            addr_nxt = q_rdata.hash[AW-1:0];
            cnt_nxt  = '0;
          end
        end
      end
      BK_PROBE: begin
        if (job_r.kind == JOB_INSERT) begin
          if (slot_empty) begin
            finish     = 1'b1;
            mem_we     = 1'b1;
            mem_wdata  = {job_r.key, job_r.value};
            count_inc  = 1'b1;
            res_load   = 1'b1;
            res_status = ST_DONE;
          end else if (last_probe) begin
            finish     = 1'b1;
            res_load   = 1'b1;
            res_status = ST_REFUSED;
          end
        end else begin
          if (slot_empty || last_probe) begin
            finish     = 1'b1;
            res_load   = 1'b1;
            res_status = ST_MISS;
          end
          if (!slot_empty && slot_key == job_r.key) begin
            finish     = 1'b1;
            res_load   = 1'b1;
            res_status = ST_HIT;
            res_value  = rd_data_r[VAL_W-1:0];
          end
        end
        // Step to the next slot, wrapping at the end of the table.
        if (!finish) begin
          addr_nxt = addr_r + ADDR_ONE;
          rd_addr  = addr_r + ADDR_ONE;
          cnt_nxt  = cnt_r + ADDR_ONE;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Control and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BK_CLEAR;
      clr_addr_r    <= '0;
      entry_count_r <= '0;
      fill_limit_r  <= FILL_LIMIT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_ONE;
      end
      if (count_inc) begin
        entry_count_r <= entry_count_r + 1'b1;
      end
      if (cfg_wr_en) begin
        fill_limit_r <= cfg_wr_data;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Job, probe position and result payload.
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    cnt_r  <= cnt_nxt;
    if (start) begin
      job_r <= q_rdata;
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
    end
  end

endmodule

### sv/hashed_subtree_size_cache.sv
// Hashed subtree size cache: open-addressed key/value table with linear probing.
// The probe engine finishes one item before it takes the next, reading memory once per
// probed slot; a refused insert is answered without a probe. The two hash stages and a
// 4-entry queue run ahead of it. After reset a clearing pass writes every slot,
// with full high.
// Depends on hssc_pkg, hssc_front, hssc_queue and hssc_back.
`timescale 1ns / 1ps

module hashed_subtree_size_cache #(
  parameter int TABLE_ADDR_BITS = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic                             in_operation,
  input  logic [hssc_pkg::KEY_W-1:0]       in_key,
  input  logic [hssc_pkg::VAL_W-1:0]       in_size_value,
  output logic                             empty,
  input  logic                             pop,
  output logic [1:0]                       out_status,
  output logic [hssc_pkg::VAL_W-1:0]       out_found_value,
  input  logic                             cfg_wr_en,
  input  logic [hssc_pkg::LIMIT_W-1:0]     cfg_wr_data
);
  import hssc_pkg::*;

  logic                q_push;
  hssc_job_t           q_wdata;
  logic                q_pop;
  hssc_job_t           q_rdata;
  logic                q_empty;
  logic [Q_CNT_W-1:0]  q_count;
  logic                clearing;

  // Hashing front end.
  hssc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_operation  (in_operation),
    .in_key        (in_key),
    .in_size_value (in_size_value),
    .clearing      (clearing),
    .q_count       (q_count),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  // Job queue.
  hssc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty),
    .q_count (q_count)
  );

  // Probe engine with the slot memory.
  hssc_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rdata         (q_rdata),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .empty           (empty),
    .pop             (pop),
    .out_status      (out_status),
    .out_found_value (out_found_value)
  );

endmodule
